/* hw/rtl/bdgd_pkg.sv */
// Shared types and constants for the button debounce / gesture detector.
// Holds configuration, state, poll and result structs and register indexes.
// No dependencies.
`default_nettype none

package bdgd_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_DEBOUNCE_TIME  = 3'd0,
    REG_INVERT_INPUT   = 3'd1,
    REG_MUTED          = 3'd2,
    REG_CLICK_MAX_TIME = 3'd3,
    REG_GAP_MAX_TIME   = 3'd4,
    REG_CLICKS_NEEDED  = 3'd5,
    REG_HOLD_TIME      = 3'd6,
    REG_HOLD_REPEAT    = 3'd7
  } cfg_idx_t;

  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] RST_DEBOUNCE_TIME = 16'd50;
  localparam logic [15:0] RST_GAP_MAX_TIME  = 16'd400;
  localparam logic [3:0]  RST_CLICKS_NEEDED = 4'd2;
  localparam logic [15:0] RST_HOLD_TIME     = 16'd1000;
  localparam logic [3:0]  CLICK_COUNT_MAX   = 4'd15;

  typedef struct packed {
    logic [15:0] debounce_time;
    logic        invert_input;
    logic        muted;
    logic [15:0] click_max_time;
    logic [15:0] gap_max_time;
    logic [3:0]  clicks_needed;
    logic [15:0] hold_time;
    logic        hold_repeat;
  } cfg_t;

  typedef struct packed {
    logic [15:0] integrator;
    logic        level;
    logic [31:0] unchanged_time;
    logic [31:0] time_now;
    logic [31:0] press_start;
    logic [31:0] last_click_time;
    logic [3:0]  click_count;
    logic        hold_sent;
  } state_t;

  typedef struct packed {
    logic        raw_level;
    logic [15:0] elapsed_ms;
  } poll_t;

  typedef struct packed {
    logic        stable;
    logic        level;
    logic        pushed;
    logic        released;
    logic        clicked;
    logic        multi_clicked;
    logic        held;
    logic [31:0] time_unchanged;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/bdgd_stream_if.sv */
// Valid/ready stream channel with a typed payload.
// Payload type is a parameter; used with bdgd_pkg structs.
`default_nettype none

interface bdgd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/button_debounce_gesture_detector_core.sv */
// Top level of the button debounce / gesture detector.
// Depends on bdgd_pkg, bdgd_stream_if and bdgd_eval.
`default_nettype none

//  channel  dir  payload           transaction
//  -------  ---  ----------------  ------------------------------------
//  poll     in   poll_t            one button sample plus elapsed ms
//  result   out  result_t          exactly one result per poll
//  cfg_*    in   index + 16b data  register write when cfg_we is high
//
// One poll a cycle sustained while result ready stays high. An accepted poll
// goes through the input register, then the evaluator into the result
// register, whose valid then rises unless a full result register stalls.
// The state update and the result load share one edge, so each poll sees the
// state left by the one before it.
// Reset (rst, synchronous) clears state and loads register defaults.
// A stalled result holds; one further poll is taken into the input register.

module button_debounce_gesture_detector_core (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  bdgd_pkg::cfg_idx_t              cfg_index,
  input  wire [bdgd_pkg::CFG_DATA_W-1:0]  cfg_data,
  bdgd_stream_if.sink                     poll,
  bdgd_stream_if.source                   result
);
  import bdgd_pkg::*;

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  result_t res_next;

  logic    s1_valid;
  poll_t   s1_poll;
  logic    res_valid;
  result_t res_data;
  logic    load_out;
  logic    poll_take;

  // result register frees when empty or drained this cycle
  assign load_out   = s1_valid && (!res_valid || result.ready);
  assign poll.ready = !s1_valid || load_out;
  assign poll_take  = poll.valid && poll.ready;

  assign result.valid = res_valid;
  assign result.data  = res_data;

  bdgd_eval u_eval (
    .cfg        (cfg),
    .state_cur  (state),
    .poll       (s1_poll),
    .state_next (state_next),
    .res        (res_next)
  );

  // control, state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid             <= 1'b0;
      res_valid            <= 1'b0;
      state                <= '0;
      cfg.debounce_time    <= RST_DEBOUNCE_TIME;
      cfg.invert_input     <= 1'b0;
      cfg.muted            <= 1'b0;
      cfg.click_max_time   <= 16'd0;
      cfg.gap_max_time     <= RST_GAP_MAX_TIME;
      cfg.clicks_needed    <= RST_CLICKS_NEEDED;
      cfg.hold_time        <= RST_HOLD_TIME;
      cfg.hold_repeat      <= 1'b0;
    end else begin
      if (poll_take) begin
        s1_valid <= 1'b1;
      end else if (load_out) begin
        s1_valid <= 1'b0;
      end

      if (load_out) begin
        res_valid <= 1'b1;
        state     <= state_next;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE_TIME:  cfg.debounce_time  <= cfg_data;
          REG_INVERT_INPUT:   cfg.invert_input   <= cfg_data[0];
          REG_MUTED:          cfg.muted          <= cfg_data[0];
          REG_CLICK_MAX_TIME: cfg.click_max_time <= cfg_data;
          REG_GAP_MAX_TIME:   cfg.gap_max_time   <= cfg_data;
          REG_CLICKS_NEEDED:  cfg.clicks_needed  <= cfg_data[3:0];
          REG_HOLD_TIME:      cfg.hold_time      <= cfg_data;
          REG_HOLD_REPEAT:    cfg.hold_repeat    <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (poll_take) begin
      s1_poll <= poll.data;
    end
    if (load_out) begin
      res_data <= res_next;
    end
  end

`ifndef ASSERT_OFF
  a_muted_time_frozen: assert property (@(posedge clk) disable iff (rst)
    (load_out && cfg.muted) |=> $stable(state.time_now))
    else $error("time base moved on a muted poll");

  a_unstable_quiet: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_data.stable) |->
      !(res_data.pushed || res_data.released || res_data.clicked ||
        res_data.multi_clicked || res_data.held))
    else $error("event on an unstable poll");

  a_click_on_release: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.clicked) |-> res_data.released)
    else $error("click without release");

  a_multi_needs_click: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.multi_clicked) |-> res_data.clicked)
    else $error("multi-click without click");

  a_hold_while_pressed: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.held) |-> (res_data.level && state.hold_sent))
    else $error("hold fired while not pressed");

  a_load_gives_result: assert property (@(posedge clk) disable iff (rst)
    load_out |=> res_valid)
    else $error("result lost after evaluation");
`endif

endmodule

`default_nettype wire

/* hw/rtl/bdgd_eval.sv */
// Single-poll evaluator: integrator, debounce, hold/click/N-click chain.
// Pure combinational next-state and result logic. Depends on bdgd_pkg.
`default_nettype none

module bdgd_eval (
  input  bdgd_pkg::cfg_t    cfg,
  input  bdgd_pkg::state_t  state_cur,
  input  bdgd_pkg::poll_t   poll,
  output bdgd_pkg::state_t  state_next,
  output bdgd_pkg::result_t res
);
  import bdgd_pkg::*;

  logic        val;
  logic [31:0] time_next;
  logic [16:0] integ_sum;
  logic [15:0] integ_next;
  logic        is_stable;
  logic        changed;
  logic [31:0] ut_base;
  logic [32:0] ut_sum;
  logic [31:0] ut_next;
  logic        hold_fire;
  logic        hold_clear;
  logic [31:0] press_dur;
  logic        click_ok;
  logic [31:0] gap;
  logic [3:0]  cnt_base;
  logic [3:0]  cnt_inc;

  assign val       = poll.raw_level ^ cfg.invert_input;
  assign time_next = state_cur.time_now + {16'd0, poll.elapsed_ms};

  // saturating integrator, clamps to full scale on the way up
  assign integ_sum = {1'b0, state_cur.integrator} + {1'b0, poll.elapsed_ms};
  always_comb begin
    if (val) begin
      integ_next = (integ_sum < {1'b0, cfg.debounce_time}) ? integ_sum[15:0]
                                                           : cfg.debounce_time;
    end else begin
      integ_next = (state_cur.integrator > poll.elapsed_ms)
                   ? (state_cur.integrator - poll.elapsed_ms) : 16'd0;
    end
  end

  assign is_stable = (integ_next == 16'd0) || (integ_next == cfg.debounce_time);
  assign changed   = val ^ state_cur.level;

  assign ut_base = changed ? 32'd0 : state_cur.unchanged_time;
  assign ut_sum  = {1'b0, ut_base} + {17'd0, poll.elapsed_ms};
  assign ut_next = ut_sum[32] ? 32'hFFFF_FFFF : ut_sum[31:0];

  assign hold_fire  = val && (ut_next >= {16'd0, cfg.hold_time}) &&
                      (!state_cur.hold_sent || cfg.hold_repeat);
  assign hold_clear = !val && state_cur.hold_sent;

  assign press_dur = time_next - state_cur.press_start;
  assign click_ok  = (cfg.click_max_time == 16'd0) ||
                     (press_dur < {16'd0, cfg.click_max_time});

  assign gap      = time_next - state_cur.last_click_time;
  assign cnt_base = (gap > {16'd0, cfg.gap_max_time}) ? 4'd0 : state_cur.click_count;
  assign cnt_inc  = (cnt_base < CLICK_COUNT_MAX) ? (cnt_base + 4'd1) : cnt_base;

  always_comb begin
    state_next = state_cur;
    res        = '0;
    if (!cfg.muted) begin
      state_next.time_now   = time_next;
      state_next.integrator = integ_next;
      if (is_stable) begin
        res.stable                = 1'b1;
        state_next.unchanged_time = ut_next;
        state_next.level          = val;
        res.pushed                = val && !state_cur.level;
        res.released              = !val && state_cur.level;
        if (hold_fire) begin
          state_next.hold_sent = 1'b1;
          res.held             = 1'b1;
        end
        if (hold_clear) begin
          state_next.hold_sent = 1'b0;
        end else if (changed) begin
          if (val) begin
            state_next.press_start = time_next;
          end else if (click_ok) begin
            res.clicked                = 1'b1;
            state_next.last_click_time = time_next;
            if (cnt_base == 4'd0) begin
              state_next.click_count = 4'd1;
            end else if (cnt_inc == cfg.clicks_needed) begin
              state_next.click_count = 4'd0;
              res.multi_clicked      = 1'b1;
            end else begin
              state_next.click_count = cnt_inc;
            end
          end
        end
      end
    end
    res.level          = state_next.level;
    res.time_unchanged = state_next.unchanged_time;
  end

endmodule

`default_nettype wire

/* test/bdgd_event_checker.sv */
// Scoreboard for the button debounce / gesture detector: mirrors the block's
// debounce and event logic and checks every result transaction in order.
// Depends on bdgd_pkg and bdgd_stream_if.
`timescale 1ns / 100ps

module bdgd_event_checker
  import bdgd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  logic [15:0] cfg_data,
  bdgd_stream_if      poll_ch,
  bdgd_stream_if      result_ch,
  output int          mismatches,
  output int          owed
);

  cfg_t    btn_cfg;
  state_t  btn;
  result_t events_due[$];
  int      results_seen;

  // One poll through the integrator and the hold / click / N-click chain.
  function automatic result_t next_button_events(poll_t p);
    result_t     r;
    logic        lvl;
    logic        was;
    logic        chain;
    logic [31:0] ms;
    logic [31:0] sum;
    logic [31:0] gap;
    r = '0;
    if (!btn_cfg.muted) begin
      lvl = p.raw_level ^ btn_cfg.invert_input;
      ms = {16'd0, p.elapsed_ms};
      btn.time_now = btn.time_now + ms;
      if (lvl) begin
        sum = {16'd0, btn.integrator} + ms;
        btn.integrator = (sum < {16'd0, btn_cfg.debounce_time}) ? sum[15:0]
                                                                 : btn_cfg.debounce_time;
      end else begin
        btn.integrator = (btn.integrator > p.elapsed_ms) ? btn.integrator - p.elapsed_ms
                                                         : 16'd0;
      end
      if (btn.integrator == 16'd0 || btn.integrator == btn_cfg.debounce_time) begin
        was = btn.level;
        chain = 1'b1;
        r.stable = 1'b1;
        if (lvl != was) btn.unchanged_time = '0;
        btn.unchanged_time = (btn.unchanged_time > 32'hFFFF_FFFF - ms) ? 32'hFFFF_FFFF
                                                                       : btn.unchanged_time + ms;
        btn.level = lvl;
        r.pushed = lvl & ~was;
        r.released = ~lvl & was;
        if (lvl && btn.unchanged_time >= {16'd0, btn_cfg.hold_time} &&
            (!btn.hold_sent || btn_cfg.hold_repeat)) begin
          btn.hold_sent = 1'b1;
          r.held = 1'b1;
        end
        // release after a hold eats the click
        if (!lvl && btn.hold_sent) begin
          btn.hold_sent = 1'b0;
          chain = 1'b0;
        end
        if (chain && lvl != was) begin
          if (lvl) begin
            btn.press_start = btn.time_now;
          end else if (btn_cfg.click_max_time == 16'd0 ||
                       (btn.time_now - btn.press_start) < {16'd0, btn_cfg.click_max_time}) begin
            gap = btn.time_now - btn.last_click_time;
            r.clicked = 1'b1;
            btn.last_click_time = btn.time_now;
            if (gap > {16'd0, btn_cfg.gap_max_time}) btn.click_count = '0;
            if (btn.click_count == 4'd0) begin
              btn.click_count = 4'd1;
            end else begin
              if (btn.click_count < CLICK_COUNT_MAX) btn.click_count = btn.click_count + 4'd1;
              if (btn.click_count == btn_cfg.clicks_needed) begin
                btn.click_count = '0;
                r.multi_clicked = 1'b1;
              end
            end
          end
        end
      end
    end
    r.level = btn.level;
    r.time_unchanged = btn.unchanged_time;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t exp;
    result_t got;
    logic    bad;
    if (rst) begin
      btn = '0;
      btn_cfg = '0;
      btn_cfg.debounce_time = RST_DEBOUNCE_TIME;
      btn_cfg.gap_max_time = RST_GAP_MAX_TIME;
      btn_cfg.clicks_needed = RST_CLICKS_NEEDED;
      btn_cfg.hold_time = RST_HOLD_TIME;
      events_due.delete();
      mismatches = 0;
      results_seen = 0;
    end else begin
      // results first: a result never belongs to a poll taken at the same edge
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.data;
        if (events_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result transaction %0d", $realtime, results_seen);
          mismatches++;
        end else begin
          exp = events_due.pop_front();
          bad = (got.stable !== exp.stable) || (got.level !== exp.level) ||
                (got.pushed !== exp.pushed) || (got.released !== exp.released) ||
                (got.clicked !== exp.clicked) || (got.multi_clicked !== exp.multi_clicked) ||
                (got.held !== exp.held) || (got.time_unchanged !== exp.time_unchanged);
          if (bad) begin
            if (mismatches < 10)
              $display("%0t: result %0d exp st%b lv%b pu%b re%b cl%b mc%b ho%b t%0d got st%b lv%b pu%b re%b cl%b mc%b ho%b t%0d",
                       $realtime, results_seen,
                       exp.stable, exp.level, exp.pushed, exp.released, exp.clicked,
                       exp.multi_clicked, exp.held, exp.time_unchanged,
                       got.stable, got.level, got.pushed, got.released, got.clicked,
                       got.multi_clicked, got.held, got.time_unchanged);
            mismatches++;
          end
        end
        results_seen++;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE_TIME:  btn_cfg.debounce_time = cfg_data;
          REG_INVERT_INPUT:   btn_cfg.invert_input = cfg_data[0];
          REG_MUTED:          btn_cfg.muted = cfg_data[0];
          REG_CLICK_MAX_TIME: btn_cfg.click_max_time = cfg_data;
          REG_GAP_MAX_TIME:   btn_cfg.gap_max_time = cfg_data;
          REG_CLICKS_NEEDED:  btn_cfg.clicks_needed = cfg_data[3:0];
          REG_HOLD_TIME:      btn_cfg.hold_time = cfg_data;
          REG_HOLD_REPEAT:    btn_cfg.hold_repeat = cfg_data[0];
          default: ;
        endcase
      end
      if (poll_ch.valid && poll_ch.ready)
        events_due.push_back(next_button_events(poll_ch.data));
    end
    owed = events_due.size();
  end

endmodule

/* test/button_debounce_gesture_detector_core_test.sv */
// Top of the button debounce / gesture detector testbench: clock, reset,
// poll stimulus, result back-pressure, register writes and the verdict.
// Depends on bdgd_pkg, bdgd_stream_if, the core and bdgd_event_checker.
`timescale 1ns / 100ps

module button_debounce_gesture_detector_core_test;
  import bdgd_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  cfg_idx_t    cfg_index;
  logic [15:0] cfg_data;

  int          mismatches;
  int          owed;

  // stimulus controls shared with the receiver process
  logic        calm;          // 1: neither side idles
  int          holdoff_asks;  // bumped to request one long result stall
  logic        inv_now;       // shadow of invert_input, to shape gestures
  logic        mute_now;      // shadow of muted
  int          live_polls;    // poll transactions taken while not muted

  bdgd_stream_if #(.payload_t(poll_t))   poll_ch ();
  bdgd_stream_if #(.payload_t(result_t)) result_ch ();

  always #1 clk = ~clk;

  button_debounce_gesture_detector_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .poll      (poll_ch),
    .result    (result_ch)
  );

  bdgd_event_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .poll_ch    (poll_ch),
    .result_ch  (result_ch),
    .mismatches (mismatches),
    .owed       (owed)
  );

  // All drive tasks start and end on a falling edge. valid stays high from
  // one poll to the next unless an idle gap is drawn, so it never gets two
  // assignments in one step.
  task automatic send_poll(input logic want, input logic [15:0] ms);
    while (!calm && $urandom_range(99) < 34) begin
      poll_ch.valid <= 1'b0;
      @(negedge clk);
    end
    poll_ch.valid <= 1'b1;
    // want is the level after inversion; undo it on the pin
    poll_ch.data.raw_level <= want ^ inv_now;
    poll_ch.data.elapsed_ms <= ms;
    @(posedge clk);
    while (!poll_ch.ready) @(posedge clk);
    if (!mute_now) live_polls++;
    @(negedge clk);
  endtask

  // Register write: one cycle of cfg_we, dropped again before the task returns.
  task automatic set_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == REG_INVERT_INPUT) inv_now = val[0];
    if (idx == REG_MUTED) mute_now = val[0];
  endtask

  // Stop offering polls and wait for every result still owed.
  // Every poll yields a result, so an empty scoreboard means the core is idle.
  task automatic settle();
    poll_ch.valid <= 1'b0;
    @(negedge clk);
    while (owed != 0) @(negedge clk);
  endtask

  // n press/release pairs, each poll advancing time by ms
  task automatic tap(input int n, input logic [15:0] ms);
    repeat (n) begin
      send_poll(1'b1, ms);
      send_poll(1'b0, ms);
    end
  endtask

  // Elapsed time per poll: mostly small so the integrator ramps over
  // several polls, with an occasional huge jump and both extremes.
  function automatic logic [15:0] pick_ms();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(40));
    if (r < 85) return 16'($urandom_range(400));
    if (r < 92) return 16'($urandom_range(3000, 1));
    if (r < 96) return 16'($urandom);
    return (r < 98) ? 16'hFFFF : 16'h0000;
  endfunction

  // Bounce in, hold for a while, bounce out, rest released.
  task automatic press_gesture();
    int unsigned hold_polls;
    hold_polls = ($urandom_range(3) == 0) ? $urandom_range(40, 10) : $urandom_range(8, 1);
    repeat ($urandom_range(3)) send_poll(1'($urandom), 16'($urandom_range(15)));
    repeat (hold_polls) send_poll(1'b1, pick_ms());
    repeat ($urandom_range(3)) send_poll(1'($urandom), 16'($urandom_range(15)));
    repeat ($urandom_range(6, 1)) send_poll(1'b0, pick_ms());
  endtask

  // Raw chatter with fully random timing; reaches the high bits of elapsed_ms.
  task automatic noise_burst();
    repeat ($urandom_range(6, 1)) send_poll(1'($urandom), 16'($urandom));
  endtask

  // New random setting for every register, extremes included.
  task automatic random_setup();
    int unsigned r;
    r = $urandom_range(99);
    set_reg(REG_DEBOUNCE_TIME, (r < 10) ? 16'd0 : (r < 15) ? 16'hFFFF :
                               (r < 20) ? 16'($urandom) : 16'($urandom_range(80, 1)));
    set_reg(REG_INVERT_INPUT, 16'($urandom_range(1)));
    set_reg(REG_MUTED, ($urandom_range(9) == 0) ? 16'd1 : 16'd0);
    r = $urandom_range(99);
    set_reg(REG_CLICK_MAX_TIME, (r < 30) ? 16'd0 : (r < 35) ? 16'hFFFF :
                                16'($urandom_range(600, 20)));
    r = $urandom_range(99);
    set_reg(REG_GAP_MAX_TIME, (r < 5) ? 16'd0 : (r < 10) ? 16'hFFFF :
                              16'($urandom_range(800, 30)));
    r = $urandom_range(99);
    set_reg(REG_CLICKS_NEEDED, (r < 70) ? 16'($urandom_range(4, 2)) :
                               16'($urandom_range(15)));
    r = $urandom_range(99);
    set_reg(REG_HOLD_TIME, (r < 5) ? 16'd0 : (r < 10) ? 16'hFFFF :
                           16'($urandom_range(1500, 50)));
    set_reg(REG_HOLD_REPEAT, 16'($urandom_range(1)));
  endtask

  // Result side: random back-pressure, plus one long stall on request so
  // the core fills both registers and drops poll ready.
  initial begin
    int holdoffs_done;
    holdoffs_done = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoffs_done != holdoff_asks) begin
        holdoffs_done++;
        result_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
      end else begin
        result_ch.ready <= calm || ($urandom_range(99) >= 34);
      end
    end
  end

  // Hard limit on the whole run.
  initial begin
    #200_000;
    $display("button_debounce_gesture_detector_core_test NOT OK");
    $finish;
  end

  initial begin
    int phase;
    int start_polls;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_DEBOUNCE_TIME;
    cfg_data = '0;
    poll_ch.valid = 1'b0;
    poll_ch.data = '0;
    calm = 1'b0;
    holdoff_asks = 0;
    inv_now = 1'b0;
    mute_now = 1'b0;
    live_polls = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- reset defaults: debounce 50, hold 1000, gap 400, two clicks ---
    send_poll(1'b0, 16'd0);       // integrator at zero: stable, no event
    send_poll(1'b0, 16'hFFFF);
    send_poll(1'b1, 16'd20);      // unstable while ramping
    send_poll(1'b1, 16'd20);
    send_poll(1'b0, 16'd5);       // bounce back down
    send_poll(1'b1, 16'd30);      // clamps at full scale: push
    send_poll(1'b1, 16'd0);
    send_poll(1'b0, 16'd50);      // release: first click
    send_poll(1'b1, 16'd60);
    send_poll(1'b0, 16'd60);      // second click inside the gap: N-click
    send_poll(1'b1, 16'd50);
    send_poll(1'b1, 16'd1000);    // hold fires
    send_poll(1'b1, 16'd500);     // no repeat
    send_poll(1'b0, 16'd50);      // release after hold: no click
    send_poll(1'b0, 16'd1);
    send_poll(1'b1, 16'hFFFF);    // push and hold on the same poll
    send_poll(1'b0, 16'hFFFF);
    settle();

    // --- zero debounce: every poll stable; fifteen clicks needed ---
    set_reg(REG_DEBOUNCE_TIME, 16'd0);
    set_reg(REG_CLICKS_NEEDED, 16'd15);
    set_reg(REG_GAP_MAX_TIME, 16'hFFFF);
    set_reg(REG_CLICK_MAX_TIME, 16'hFFFF);
    set_reg(REG_HOLD_TIME, 16'hFFFF);
    tap(16, 16'd1);
    tap(2, 16'd0);
    settle();

    // --- clicks needed below two: count keeps climbing, no N-click ever ---
    set_reg(REG_CLICKS_NEEDED, 16'd0);
    tap(4, 16'd3);
    settle();
    set_reg(REG_CLICKS_NEEDED, 16'd1);
    set_reg(REG_GAP_MAX_TIME, 16'd0);
    tap(2, 16'd0);
    tap(2, 16'd1);
    settle();

    // --- inverted pin, hold at zero time with repeat, tight click limit ---
    set_reg(REG_INVERT_INPUT, 16'd1);
    set_reg(REG_HOLD_TIME, 16'd0);
    set_reg(REG_HOLD_REPEAT, 16'd1);
    set_reg(REG_CLICK_MAX_TIME, 16'd1);
    set_reg(REG_CLICKS_NEEDED, 16'd2);
    set_reg(REG_DEBOUNCE_TIME, 16'd5);
    send_poll(1'b1, 16'd5);       // push with hold at once
    send_poll(1'b1, 16'd0);       // hold again
    send_poll(1'b0, 16'd5);       // release after a hold: no click
    settle();
    set_reg(REG_HOLD_TIME, 16'hFFFF);
    set_reg(REG_DEBOUNCE_TIME, 16'd0);
    send_poll(1'b1, 16'd0);
    send_poll(1'b0, 16'd0);       // zero-length press beats a limit of one
    send_poll(1'b1, 16'd2);
    send_poll(1'b0, 16'd2);       // too long for a click
    settle();

    // --- muted: nothing moves, not even the time base ---
    set_reg(REG_MUTED, 16'd1);
    send_poll(1'b1, 16'd100);
    send_poll(1'b0, 16'd7);
    send_poll(1'b1, 16'hFFFF);
    settle();

    // --- debounce lowered under a partly charged integrator ---
    set_reg(REG_MUTED, 16'd0);
    set_reg(REG_INVERT_INPUT, 16'd0);
    set_reg(REG_HOLD_REPEAT, 16'd0);
    set_reg(REG_HOLD_TIME, 16'd1000);
    set_reg(REG_CLICK_MAX_TIME, 16'd0);
    set_reg(REG_DEBOUNCE_TIME, 16'd1000);
    send_poll(1'b1, 16'd400);
    settle();
    set_reg(REG_DEBOUNCE_TIME, 16'd100);
    send_poll(1'b1, 16'd10);      // clamps to the new full scale: push
    send_poll(1'b0, 16'd30);
    send_poll(1'b0, 16'hFFFF);
    settle();

    // --- random phases: mostly gestures, some chatter ---
    for (phase = 0; phase < 8; phase++) begin
      settle();
      random_setup();
      if (phase == 2) holdoff_asks++;   // long result stall while polls keep coming
      calm = (phase == 5);              // one phase with no idling at all
      if (mute_now) begin
        repeat (30) noise_burst();
      end else begin
        start_polls = live_polls;
        while (live_polls - start_polls < 100) begin
          if ($urandom_range(3) == 0) noise_burst();
          else press_gesture();
        end
      end
    end
    settle();
    calm = 1'b0;

    // --- soak: full-scale debounce, held pin, huge steps; once past the
    //     hold time, hold repeats on every poll ---
    set_reg(REG_MUTED, 16'd0);
    set_reg(REG_INVERT_INPUT, 16'd0);
    set_reg(REG_DEBOUNCE_TIME, 16'hFFFF);
    set_reg(REG_HOLD_TIME, 16'hFFFF);
    set_reg(REG_HOLD_REPEAT, 16'd1);
    set_reg(REG_CLICK_MAX_TIME, 16'd0);
    calm = 1'b1;
    repeat (20) send_poll(1'b1, 16'hFFFF);
    calm = 1'b0;
    send_poll(1'b0, 16'hFFFF);    // release after a repeated hold
    send_poll(1'b1, 16'd10);
    send_poll(1'b1, 16'hFFFF);
    send_poll(1'b0, 16'hFFFF);
    settle();

    // leave margin for any stray result
    repeat (10) @(negedge clk);
    if (mismatches == 0 && owed == 0)
      $display("button_debounce_gesture_detector_core_test OK");
    else
      $display("button_debounce_gesture_detector_core_test NOT OK");
    $finish;
  end

endmodule
